[hdl/qdec_pkg.sv]
// Package for the quadrature decoder with speed estimate.
// Holds the sequencer state type, command and transition codes, the
// transition table and fixed constants. No dependencies.
package qdec_pkg;

  // Command codes of the input beat
  typedef enum logic [1:0] {
    CMD_SAMPLE  = 2'd0,
    CMD_TIMEOUT = 2'd1,
    CMD_CLEAR   = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  // Transition classes out of the pin-state table
  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_BACK = 2'd2,
    STEP_BAD  = 2'd3
  } step_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_DECODE  = 3'd1,
    ST_DIV     = 3'd2,
    ST_MUL_NEW = 3'd3,
    ST_MUL_OLD = 3'd4,
    ST_BLEND   = 3'd5,
    ST_FINISH  = 3'd6
  } state_t;

  // Register indexes on the configuration port
  typedef enum logic {
    REG_FILTER_GAIN = 1'b0,
    REG_TIMEOUT_US  = 1'b1
  } reg_idx_t;

  localparam logic [16:0] GAIN_ONE    = 17'd65536;
  localparam logic [16:0] GAIN_RESET  = 17'd6554;
  localparam logic [31:0] TIMEOUT_RST = 32'd1000000;
  localparam logic [31:0] SPEED_SAT   = 32'h7FFF_FFFF;
  localparam logic [49:0] ROUND_HALF  = 50'd32768;

  // Classify a move from the previous pin state to the current one
  function automatic step_t step_code(input logic [1:0] cur, input logic [1:0] prev);
    step_t code;
    code = STEP_NONE;
    case ({cur, prev})
      4'b00_00: code = STEP_NONE;
      4'b00_01: code = STEP_BACK;
      4'b00_10: code = STEP_FWD;
      4'b00_11: code = STEP_BAD;
      4'b01_00: code = STEP_FWD;
      4'b01_01: code = STEP_NONE;
      4'b01_10: code = STEP_BAD;
      4'b01_11: code = STEP_BACK;
      4'b10_00: code = STEP_BACK;
      4'b10_01: code = STEP_BAD;
      4'b10_10: code = STEP_NONE;
      4'b10_11: code = STEP_FWD;
      4'b11_00: code = STEP_BAD;
      4'b11_01: code = STEP_FWD;
      4'b11_10: code = STEP_BACK;
      4'b11_11: code = STEP_NONE;
      default:  code = STEP_NONE;
    endcase
    return code;
  endfunction

endpackage

[hdl/qdec_div.sv]
// Serial restoring divider, one quotient bit per cycle.
// Unsigned 32-bit numerator and divisor. No package dependencies.
module qdec_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] numer,
  input  logic [31:0] denom,
  output logic        done,
  output logic [31:0] quot
);

  logic        busy;
  logic [4:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] dvs;
  logic [32:0] shifted;
  logic [32:0] diff;

  // Trial subtract of the divisor from the shifted remainder
  assign shifted = {rem, quo[31]};
  assign diff    = shifted - {1'b0, dvs};

  // Control: run 32 iterations, pulse done after the last
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: load operands, then shift in one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= numer;
      dvs <= denom;
    end else if (busy) begin
      if (!diff[32]) begin
        rem <= diff[31:0];
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= shifted[31:0];
        quo <= {quo[30:0], 1'b0};
      end
    end
  end

  assign quot = quo;

endmodule

[hdl/quadrature_decoder_with_speed.sv]
// Quadrature decoder with step count and filtered speed estimate.
// Depends on qdec_pkg and qdec_div.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one command per beat: a pin
//   sample, a timeout check or a step-count clear, with a microsecond time.
//   Output channel (out_valid / out_stall) returns one beat per input beat:
//   status, step_count and filtered speed (signed, SPEED_FRAC_BITS fraction).
//   Configuration goes through an APB-style port: filter_gain at 0x0,
//   timeout_us at 0x4; pready is always high, reads return the register.
// Processing:
//   a beat with no step goes from decode straight to the output load; a step
//   with zero dt skips the divider; other steps pass decode, the serial divider
//   for (1e6 << SPEED_FRAC_BITS) / dt, ST_MUL_NEW, ST_MUL_OLD, blend and output
//   load. in_stall is high while a beat is in work, so no new beat is taken before the last result is loaded.
// Reset: rst is synchronous; it clears pins, count, speed, step time and
//   restores register defaults. No clearing pass is needed.
// Stall: a finished result holds in the output register while out_stall is
//   high; the next input beat may be accepted meanwhile, and its result waits
//   until the register frees.
module quadrature_decoder_with_speed #(
  parameter int SPEED_FRAC_BITS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // Input channel
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         cmd,
  input  logic               pin_a,
  input  logic               pin_b,
  input  logic [31:0]        time_us,
  // Output channel
  output logic               out_valid,
  input  logic               out_stall,
  output logic               status,
  output logic signed [31:0] step_count,
  output logic signed [31:0] speed,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam logic [31:0] NUMER = 32'(64'd1000000 << SPEED_FRAC_BITS);

  qdec_pkg::state_t state;
  qdec_pkg::state_t state_next;

  // Configuration registers
  logic [16:0] filter_gain;
  logic [31:0] timeout_us;

  // Block state
  logic [1:0]         prev_pins;
  logic [31:0]        position;
  logic signed [31:0] filtered_speed;
  logic [31:0]        last_step_time;

  // Latched input beat and work registers
  logic [1:0]          cmd_q;
  logic [1:0]          pins_q;
  logic [31:0]         time_q;
  logic                status_q;
  logic                back_q;
  logic signed [31:0]  fresh;
  logic signed [49:0]  prod;
  logic signed [50:0]  acc;

  // Decode helpers
  qdec_pkg::step_t     code;
  logic [31:0]         dt;
  logic                is_step;
  logic                div_start;
  logic                div_done;
  logic [31:0]         div_quot;
  logic [31:0]         mag;
  logic [16:0]         gain_clamped;
  logic signed [17:0]  mul_a;
  logic signed [31:0]  mul_b;
  logic signed [50:0]  blend_sum;
  logic                out_free;
  logic                cfg_write;

  assign code    = qdec_pkg::step_code(pins_q, prev_pins);
  assign dt      = time_q - last_step_time;
  assign is_step = (cmd_q == qdec_pkg::CMD_SAMPLE) &&
                   ((code == qdec_pkg::STEP_FWD) || (code == qdec_pkg::STEP_BACK));
  assign out_free = !out_valid || !out_stall;

  // Saturate the divider quotient to the positive range
  assign mag = (div_quot > qdec_pkg::SPEED_SAT) ? qdec_pkg::SPEED_SAT : div_quot;

  // Clamp gain to one and share the multiplier over both filter terms
  assign gain_clamped = (filter_gain > qdec_pkg::GAIN_ONE) ? qdec_pkg::GAIN_ONE : filter_gain;
  always_comb begin
    if (state == qdec_pkg::ST_MUL_NEW) begin
      mul_a = signed'({1'b0, gain_clamped});
      mul_b = fresh;
    end else begin
      mul_a = signed'({1'b0, qdec_pkg::GAIN_ONE - gain_clamped});
      mul_b = filtered_speed;
    end
  end
  assign blend_sum = acc + 51'(prod);

  qdec_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .numer (NUMER),
    .denom (dt),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  always_comb begin
    case (qdec_pkg::reg_idx_t'(paddr[2]))
      qdec_pkg::REG_FILTER_GAIN: prdata = {15'd0, filter_gain};
      qdec_pkg::REG_TIMEOUT_US:  prdata = timeout_us;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_gain <= qdec_pkg::GAIN_RESET;
      timeout_us  <= qdec_pkg::TIMEOUT_RST;
    end else if (cfg_write) begin
      case (qdec_pkg::reg_idx_t'(paddr[2]))
        qdec_pkg::REG_FILTER_GAIN: filter_gain <= pwdata[16:0];
        qdec_pkg::REG_TIMEOUT_US:  timeout_us  <= pwdata;
        default:                   ;
      endcase
    end
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) state <= qdec_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Next state and handshake outputs
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    case (state)
      qdec_pkg::ST_IDLE: begin
        // Hold off input beats while reset is applied
        in_stall = rst;
        if (in_valid) state_next = qdec_pkg::ST_DECODE;
      end
      qdec_pkg::ST_DECODE: begin
        if (is_step) begin
          if (dt == 32'd0) begin
            state_next = qdec_pkg::ST_MUL_NEW;
          end else begin
            div_start  = 1'b1;
            state_next = qdec_pkg::ST_DIV;
          end
        end else begin
          state_next = qdec_pkg::ST_FINISH;
        end
      end
      qdec_pkg::ST_DIV: begin
        if (div_done) state_next = qdec_pkg::ST_MUL_NEW;
      end
      qdec_pkg::ST_MUL_NEW: state_next = qdec_pkg::ST_MUL_OLD;
      qdec_pkg::ST_MUL_OLD: state_next = qdec_pkg::ST_BLEND;
      qdec_pkg::ST_BLEND:   state_next = qdec_pkg::ST_FINISH;
      qdec_pkg::ST_FINISH: begin
        if (out_free) state_next = qdec_pkg::ST_IDLE;
      end
      default: state_next = qdec_pkg::ST_IDLE;
    endcase
  end

  // Latch the input beat
  always_ff @(posedge clk) begin
    if (state == qdec_pkg::ST_IDLE && in_valid) begin
      cmd_q  <= cmd;
      pins_q <= {pin_b, pin_a};
      time_q <= time_us;
    end
  end

  // Block state updates
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pins      <= '0;
      position       <= '0;
      filtered_speed <= '0;
      last_step_time <= '0;
      status_q       <= 1'b0;
    end else begin
      case (state)
        qdec_pkg::ST_DECODE: begin
          status_q <= 1'b0;
          case (qdec_pkg::cmd_t'(cmd_q))
            qdec_pkg::CMD_SAMPLE: begin
              prev_pins <= pins_q;
              if (code == qdec_pkg::STEP_BAD) begin
                status_q <= 1'b1;
              end else if (is_step) begin
                position       <= (code == qdec_pkg::STEP_BACK) ? position - 32'd1
                                                                : position + 32'd1;
                last_step_time <= time_q;
              end
            end
            qdec_pkg::CMD_TIMEOUT: begin
              if (dt > timeout_us) filtered_speed <= '0;
            end
            qdec_pkg::CMD_CLEAR: position <= '0;
            default: ;
          endcase
        end
        qdec_pkg::ST_BLEND: filtered_speed <= blend_sum[47:16];
        default: ;
      endcase
    end
  end

  // Speed datapath: raw speed, products and rounding accumulator
  always_ff @(posedge clk) begin
    case (state)
      qdec_pkg::ST_DECODE: begin
        back_q <= (code == qdec_pkg::STEP_BACK);
        fresh  <= (code == qdec_pkg::STEP_BACK) ? -signed'(qdec_pkg::SPEED_SAT)
                                                : signed'(qdec_pkg::SPEED_SAT);
      end
      qdec_pkg::ST_DIV: begin
        if (div_done) fresh <= back_q ? -signed'(mag) : signed'(mag);
      end
      qdec_pkg::ST_MUL_NEW: prod <= mul_a * mul_b;
      qdec_pkg::ST_MUL_OLD: begin
        prod <= mul_a * mul_b;
        acc  <= 51'(prod) + 51'(signed'(qdec_pkg::ROUND_HALF));
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (state == qdec_pkg::ST_FINISH && out_free) out_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == qdec_pkg::ST_FINISH && out_free) begin
      status     <= status_q;
      step_count <= position;
      speed      <= filtered_speed;
    end
  end

endmodule
